[sv/clipped_rotated_line_rasterizer_unit_defines.svh]
// ----------------------------------------------------------------------------
// clipped rotated line rasterizer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ROTATED_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define CLIPPED_ROTATED_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define CRLR_ASSERT_IMP(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("crlr port check failed");

// next-cycle implication under reset
`define CRLR_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("crlr port check failed");

`endif

[sv/crlr_pkg.sv]
// ----------------------------------------------------------------------------
// crlr_pkg
// types and constants shared by the line rasterizer sequencer and datapath
// ----------------------------------------------------------------------------
package crlr_pkg;

	localparam int COORD_W = 12;
	localparam int DELTA_W = 13;
	localparam int ERR_W   = 16;
	localparam int PIX_W   = 6;
	localparam int COLOR_W = 8;
	localparam int ROT_W   = 2;
	localparam int STEP_W  = 2;

	typedef logic [STEP_W-1:0] step_t;

	// jump conditions of the microprogram
	typedef enum logic [1:0] {
		COND_ALWAYS    = 2'd0,
		COND_NOT_START = 2'd1,
		COND_NOT_END   = 2'd2,
		COND_NEVER     = 2'd3
	} cond_t;

	// one control word of the program
	typedef struct packed {
		logic  idle;
		logic  init;
		logic  walk;
		logic  finish;
		cond_t cond;
		step_t target;
	} ctrl_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic start;
		logic at_end;
	} status_t;

	// rotation codes
	localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
	localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

endpackage

[sv/crlr_seq.sv]
// ----------------------------------------------------------------------------
// crlr_seq
// step counter and control store for the line walk
// ----------------------------------------------------------------------------
module crlr_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  crlr_pkg::status_t   status,
	output crlr_pkg::ctrl_t     ctrl
);

	localparam crlr_pkg::step_t STEP_IDLE = 2'd0;
	localparam crlr_pkg::step_t STEP_INIT = 2'd1;
	localparam crlr_pkg::step_t STEP_WALK = 2'd2;
	localparam crlr_pkg::step_t STEP_FIN  = 2'd3;

	crlr_pkg::step_t pc_q;
	logic            take;

	// control store: idle, init, walk, finish, cond, target
	function automatic crlr_pkg::ctrl_t rom(input crlr_pkg::step_t pc);
		crlr_pkg::ctrl_t w;
		w = '0;
		case (pc)
			STEP_IDLE: begin
				w.idle   = 1'b1;
				w.cond   = crlr_pkg::COND_NOT_START;
				w.target = STEP_IDLE;
			end
			STEP_INIT: begin
				w.init   = 1'b1;
				w.cond   = crlr_pkg::COND_NEVER;
				w.target = STEP_IDLE;
			end
			STEP_WALK: begin
				w.walk   = 1'b1;
				w.cond   = crlr_pkg::COND_NOT_END;
				w.target = STEP_WALK;
			end
			STEP_FIN: begin
				w.finish = 1'b1;
				w.cond   = crlr_pkg::COND_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.cond   = crlr_pkg::COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

	assign ctrl = rom(pc_q);

	always_comb begin
		case (ctrl.cond)
			crlr_pkg::COND_ALWAYS:    take = 1'b1;
			crlr_pkg::COND_NOT_START: take = ~status.start;
			crlr_pkg::COND_NOT_END:   take = ~status.at_end;
			crlr_pkg::COND_NEVER:     take = 1'b0;
			default:                  take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + crlr_pkg::step_t'(1);
		end
	end

endmodule

[sv/crlr_dp.sv]
// ----------------------------------------------------------------------------
// crlr_dp
// line walk datapath: error term, clipping, rotation, one-pixel hold
// ----------------------------------------------------------------------------
module crlr_dp #(
	parameter int DISP_WIDTH  = 64,
	parameter int DISP_HEIGHT = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  crlr_pkg::ctrl_t                      ctrl,
	input  logic                                 start,
	input  logic [crlr_pkg::ROT_W-1:0]           rotation,
	input  logic signed [crlr_pkg::COORD_W-1:0]  start_x,
	input  logic signed [crlr_pkg::COORD_W-1:0]  start_y,
	input  logic signed [crlr_pkg::COORD_W-1:0]  end_x,
	input  logic signed [crlr_pkg::COORD_W-1:0]  end_y,
	input  logic [crlr_pkg::COLOR_W-1:0]         color,
	output logic                                 at_end,
	output logic                                 result_strobe,
	output logic [crlr_pkg::PIX_W-1:0]           pixel_x,
	output logic [crlr_pkg::PIX_W-1:0]           pixel_y,
	output logic [crlr_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                 visible,
	output logic                                 last
);

	localparam int CW = crlr_pkg::COORD_W;
	localparam int DW = crlr_pkg::DELTA_W;
	localparam int EW = crlr_pkg::ERR_W;
	localparam int PW = crlr_pkg::PIX_W;

	localparam logic signed [DW-1:0] LIM_W = DW'(DISP_WIDTH);
	localparam logic signed [DW-1:0] LIM_H = DW'(DISP_HEIGHT);
	localparam logic [CW-1:0]        W_M1  = CW'(DISP_WIDTH - 1);
	localparam logic [CW-1:0]        H_M1  = CW'(DISP_HEIGHT - 1);

	logic signed [CW-1:0] x_q, y_q, xe_q, ye_q;
	logic [crlr_pkg::COLOR_W-1:0] color_q;
	logic signed [DW-1:0] dx_q, dy_q;
	logic signed [EW-1:0] err_q;
	logic                 sxn_q, syn_q;
	logic                 pend_v_q;
	logic [PW-1:0]        pend_x_q, pend_y_q;

	logic signed [DW-1:0] x_w, y_w, xe_w, ye_w, ddx, ddy;
	logic signed [DW-1:0] lim_x, lim_y;
	logic signed [EW:0]   e2;
	logic signed [EW-1:0] err_n;
	logic                 step_x, step_y, on_scr;
	logic [CW-1:0]        map_x, map_y;

	assign x_w  = DW'(x_q);
	assign y_w  = DW'(y_q);
	assign xe_w = DW'(xe_q);
	assign ye_w = DW'(ye_q);
	assign ddx  = xe_w - x_w;
	assign ddy  = ye_w - y_w;

	assign at_end = (x_q == xe_q) && (y_q == ye_q);

	// logical screen swaps sides at 90 and 270 degrees
	assign lim_x  = rotation[0] ? LIM_H : LIM_W;
	assign lim_y  = rotation[0] ? LIM_W : LIM_H;
	assign on_scr = !x_q[CW-1] && !y_q[CW-1] && (x_w < lim_x) && (y_w < lim_y);

	always_comb begin
		case (rotation)
			crlr_pkg::ROT_90: begin
				map_x = W_M1 - y_q;
				map_y = x_q;
			end
			crlr_pkg::ROT_180: begin
				map_x = W_M1 - x_q;
				map_y = H_M1 - y_q;
			end
			crlr_pkg::ROT_270: begin
				map_x = y_q;
				map_y = H_M1 - x_q;
			end
			default: begin
				map_x = x_q;
				map_y = y_q;
			end
		endcase
	end

	// error term step
	assign e2     = {err_q, 1'b0};
	assign step_x = e2 >= (EW+1)'(dy_q);
	assign step_y = e2 <= (EW+1)'(dx_q);
	assign err_n  = err_q + (step_x ? EW'(dy_q) : '0) + (step_y ? EW'(dx_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q      <= 1'b0;
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			if (ctrl.idle && start) begin
				pend_v_q <= 1'b0;
			end
			if (ctrl.walk && on_scr) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					result_strobe <= 1'b1;
				end
			end
			if (ctrl.finish) begin
				pend_v_q      <= 1'b0;
				result_strobe <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.idle && start) begin
			x_q     <= start_x;
			y_q     <= start_y;
			xe_q    <= end_x;
			ye_q    <= end_y;
			color_q <= color;
		end
		if (ctrl.init) begin
			dx_q  <= ddx[DW-1] ? -ddx : ddx;
			dy_q  <= ddy[DW-1] ? ddy : -ddy;
			sxn_q <= !(x_w < xe_w);
			syn_q <= !(y_w < ye_w);
			err_q <= EW'(ddx[DW-1] ? -ddx : ddx) + EW'(ddy[DW-1] ? ddy : -ddy);
		end
		if (ctrl.walk) begin
			if (on_scr) begin
				pend_x_q <= map_x[PW-1:0];
				pend_y_q <= map_y[PW-1:0];
				// previous pixel is known not to be the final one
				pixel_x     <= pend_x_q;
				pixel_y     <= pend_y_q;
				pixel_color <= color_q;
				visible     <= 1'b1;
				last        <= 1'b0;
			end
			if (!at_end) begin
				err_q <= err_n;
				if (step_x) begin
					x_q <= sxn_q ? x_q - CW'(1) : x_q + CW'(1);
				end
				if (step_y) begin
					y_q <= syn_q ? y_q - CW'(1) : y_q + CW'(1);
				end
			end
		end
		if (ctrl.finish) begin
			pixel_x     <= pend_v_q ? pend_x_q : '0;
			pixel_y     <= pend_v_q ? pend_y_q : '0;
			pixel_color <= pend_v_q ? color_q : '0;
			visible     <= pend_v_q;
			last        <= 1'b1;
		end
	end

endmodule

[sv/clipped_rotated_line_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// clipped_rotated_line_rasterizer_unit
// bresenham line walk with screen clipping and panel rotation
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                 word
// command   in         start & !busy             start_x start_y end_x end_y color
// result    out        result_strobe (no stall)  pixel_x pixel_y pixel_color visible last
// config    in         cfg_valid & cfg_ready     cfg_data (rotation)
//
// a line of n = max(|dx|,|dy|)+1 points keeps busy high from the accepting edge
// through one init step, one walk step per point and one finish step
// the walk step of the microprogram makes one bresenham step a cycle
// each pixel word leaves in the cycle after the next visible point is found;
// the final word (last set) leaves in the cycle after the finish step
// reset returns the step counter to idle and rotation to 0 degrees
// results cannot be stalled; cfg_ready is always high
//
module clipped_rotated_line_rasterizer_unit #(
	parameter int DISP_WIDTH  = 64,
	parameter int DISP_HEIGHT = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [crlr_pkg::COORD_W-1:0]  start_x,
	input  logic signed [crlr_pkg::COORD_W-1:0]  start_y,
	input  logic signed [crlr_pkg::COORD_W-1:0]  end_x,
	input  logic signed [crlr_pkg::COORD_W-1:0]  end_y,
	input  logic [crlr_pkg::COLOR_W-1:0]         color,
	// result channel
	output logic                                 result_strobe,
	output logic [crlr_pkg::PIX_W-1:0]           pixel_x,
	output logic [crlr_pkg::PIX_W-1:0]           pixel_y,
	output logic [crlr_pkg::COLOR_W-1:0]         pixel_color,
	output logic                                 visible,
	output logic                                 last,
	// config channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [crlr_pkg::ROT_W-1:0]           cfg_data
);

	crlr_pkg::ctrl_t   ctrl;
	crlr_pkg::status_t status;
	logic [crlr_pkg::ROT_W-1:0] rotation_q;
	logic at_end;

	// rotation register; the user must write it only between commands, the block does not enforce it
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= crlr_pkg::ROT_0;
		end else if (cfg_valid && cfg_ready) begin
			rotation_q <= cfg_data;
		end
	end

	// busy whenever the program is past its idle step
	assign busy = ~ctrl.idle;

	assign status.start  = start;
	assign status.at_end = at_end;

	crlr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	crlr_dp #(
		.DISP_WIDTH  (DISP_WIDTH),
		.DISP_HEIGHT (DISP_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.start         (start),
		.rotation      (rotation_q),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.color         (color),
		.at_end        (at_end),
		.result_strobe (result_strobe),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.visible       (visible),
		.last          (last)
	);

endmodule

[sv/crlr_checker.sv]
// ----------------------------------------------------------------------------
// crlr_checker
// port-level checks of the line rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`include "clipped_rotated_line_rasterizer_unit_defines.svh"

module crlr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             start,
	input logic                             busy,
	input logic                             result_strobe,
	input logic [crlr_pkg::PIX_W-1:0]       pixel_x,
	input logic [crlr_pkg::PIX_W-1:0]       pixel_y,
	input logic [crlr_pkg::COLOR_W-1:0]     pixel_color,
	input logic                             visible,
	input logic                             last
);

	// an empty-line marker always closes its command
	`CRLR_ASSERT_IMP(a_empty_is_last, clk, arst_n, result_strobe && !visible, last)

	// the empty-line marker carries zero payload
	`CRLR_ASSERT_IMP(a_empty_zero, clk, arst_n, result_strobe && !visible, pixel_x == '0 && pixel_y == '0 && pixel_color == '0)

	// an accepted command keeps the block busy in the next cycle
	`CRLR_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// the final word of a command is never followed directly by another word
	`CRLR_ASSERT_NEXT(a_last_gap, clk, arst_n, result_strobe && last, !result_strobe)

endmodule

bind clipped_rotated_line_rasterizer_unit crlr_checker u_crlr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.result_strobe (result_strobe),
	.pixel_x       (pixel_x),
	.pixel_y       (pixel_y),
	.pixel_color   (pixel_color),
	.visible       (visible),
	.last          (last)
);

[verif/tb_clipped_rotated_line_rasterizer_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_rotated_line_rasterizer_unit
// line commands go in through the start/busy handshake, and every accepted
// command is walked by a local bresenham model at the current rotation. the
// model queues the pixel words it predicts. a checker compares every strobed
// result word with the oldest queued word, one field at a time. directed
// corner cases come first, then random phases at each rotation with and
// without sender idling
// ----------------------------------------------------------------------------
module tb_clipped_rotated_line_rasterizer_unit;

	localparam int DISP_WIDTH  = 64;
	localparam int DISP_HEIGHT = 64;
	localparam int MAX_WORDS   = 64;
	localparam int CYCLE_LIMIT = 5000000;
	localparam int REPORT_MAX  = 10;

	localparam int COORD_W = crlr_pkg::COORD_W;
	localparam int PIX_W   = crlr_pkg::PIX_W;
	localparam int COLOR_W = crlr_pkg::COLOR_W;
	localparam int ROT_W   = crlr_pkg::ROT_W;

	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [COLOR_W-1:0] col;
		logic               vis;
		logic               lst;
	} pixel_word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic signed [COORD_W-1:0] start_x = '0;
	logic signed [COORD_W-1:0] start_y = '0;
	logic signed [COORD_W-1:0] end_x = '0;
	logic signed [COORD_W-1:0] end_y = '0;
	logic [COLOR_W-1:0]        color = '0;
	logic                      result_strobe;
	logic [PIX_W-1:0]          pixel_x;
	logic [PIX_W-1:0]          pixel_y;
	logic [COLOR_W-1:0]        pixel_color;
	logic                      visible;
	logic                      last;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [ROT_W-1:0]          cfg_data = '0;

	// local copy of the rotation register, reset value 0 degrees
	logic [ROT_W-1:0] cur_rotation = crlr_pkg::ROT_0;
	pixel_word_t      expected_pixels[$];
	int               mismatch_count = 0;
	int               cycle_count = 0;

	clipped_rotated_line_rasterizer_unit #(
		.DISP_WIDTH  (DISP_WIDTH),
		.DISP_HEIGHT (DISP_HEIGHT)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.color         (color),
		.result_strobe (result_strobe),
		.pixel_x       (pixel_x),
		.pixel_y       (pixel_y),
		.pixel_color   (pixel_color),
		.visible       (visible),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// walks the line and queues one word per visible point, or the empty marker
	function automatic void predict_line_pixels(input logic signed [COORD_W-1:0] x0,
			input logic signed [COORD_W-1:0] y0, input logic signed [COORD_W-1:0] x1,
			input logic signed [COORD_W-1:0] y1, input logic [COLOR_W-1:0] col);
		int x, y, xe, ye, dx, dy, stx, sty, err, e2, scr_w, scr_h, px, py;
		pixel_word_t line_words[$];
		pixel_word_t w;
		x = int'(x0);
		y = int'(y0);
		xe = int'(x1);
		ye = int'(y1);
		dx = (xe > x) ? xe - x : x - xe;
		dy = (y > ye) ? ye - y : y - ye;
		stx = (x < xe) ? 1 : -1;
		sty = (y < ye) ? 1 : -1;
		err = dx + dy;
		// logical screen swaps its sides at 90 and 270 degrees
		scr_w = cur_rotation[0] ? DISP_HEIGHT : DISP_WIDTH;
		scr_h = cur_rotation[0] ? DISP_WIDTH : DISP_HEIGHT;
		forever begin
			if (x >= 0 && y >= 0 && x < scr_w && y < scr_h &&
					line_words.size() < MAX_WORDS) begin
				case (cur_rotation)
					crlr_pkg::ROT_90: begin
						px = DISP_WIDTH - 1 - y;
						py = x;
					end
					crlr_pkg::ROT_180: begin
						px = DISP_WIDTH - 1 - x;
						py = DISP_HEIGHT - 1 - y;
					end
					crlr_pkg::ROT_270: begin
						px = y;
						py = DISP_HEIGHT - 1 - x;
					end
					default: begin
						px = x;
						py = y;
					end
				endcase
				w.px = px[PIX_W-1:0];
				w.py = py[PIX_W-1:0];
				w.col = col;
				w.vis = 1'b1;
				w.lst = 1'b0;
				line_words.push_back(w);
			end
			if (x == xe && y == ye)
				break;
			e2 = 2 * err;
			if (e2 >= dy) begin
				err += dy;
				x += stx;
			end
			if (e2 <= dx) begin
				err += dx;
				y += sty;
			end
		end
		if (line_words.size() == 0) begin
			// nothing on screen: a single marker word
			w = '0;
			w.lst = 1'b1;
			line_words.push_back(w);
		end else begin
			line_words[line_words.size()-1].lst = 1'b1;
		end
		foreach (line_words[i])
			expected_pixels.push_back(line_words[i]);
	endfunction

	// result checker; the receiver cannot stall so every strobe is a word
	always @(posedge clk) begin
		pixel_word_t want;
		if (arst_n && result_strobe) begin
			if (expected_pixels.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX)
					$display("unexpected word: x=%0d y=%0d col=%0d vis=%0b last=%0b",
						pixel_x, pixel_y, pixel_color, visible, last);
			end else begin
				want = expected_pixels.pop_front();
				if (pixel_x !== want.px || pixel_y !== want.py || pixel_color !== want.col ||
						visible !== want.vis || last !== want.lst) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display({"mismatch: want x=%0d y=%0d col=%0d vis=%0b last=%0b, ",
							"got x=%0d y=%0d col=%0d vis=%0b last=%0b"},
							want.px, want.py, want.col, want.vis, want.lst,
							pixel_x, pixel_y, pixel_color, visible, last);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// drives one command at this edge and returns at its accepting edge
	task automatic send_line(input logic signed [COORD_W-1:0] x0,
			input logic signed [COORD_W-1:0] y0, input logic signed [COORD_W-1:0] x1,
			input logic signed [COORD_W-1:0] y1, input logic [COLOR_W-1:0] col);
		start <= 1'b1;
		start_x <= x0;
		start_y <= y0;
		end_x <= x1;
		end_y <= y1;
		color <= col;
		do @(posedge clk); while (busy);
		predict_line_pixels(x0, y0, x1, y1, col);
	endtask

	// sender gap of random length after an accepted command, taken with a chance of idle_pct percent
	task automatic sender_gap(input int idle_pct);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
	endtask

	// lowers start and waits until every queued word has come back
	task automatic drain_lines;
		start <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_rotation(input logic [ROT_W-1:0] rot);
		cfg_valid <= 1'b1;
		cfg_data <= rot;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_rotation = rot;
	endtask

	// mostly short lines around the screen, some spanning the whole range
	task automatic random_line(input int idle_pct);
		logic signed [COORD_W-1:0] x0, y0, x1, y1;
		int pick;
		pick = $urandom_range(99);
		x0 = COORD_W'($urandom_range(110) - 24);
		y0 = COORD_W'($urandom_range(110) - 24);
		x1 = COORD_W'($urandom_range(110) - 24);
		y1 = COORD_W'($urandom_range(110) - 24);
		if (pick < 6) begin
			x0 = COORD_W'($urandom_range(4095));
			y0 = COORD_W'($urandom_range(4095));
			x1 = COORD_W'($urandom_range(4095));
			y1 = COORD_W'($urandom_range(4095));
		end else if (pick < 12) begin
			x1 = COORD_W'($urandom_range(4095));
			y0 = COORD_W'($urandom_range(4095));
		end else if (pick < 26) begin
			x1 = x0;
			y1 = y0;
		end else if (pick < 40) begin
			// axis-aligned runs hit the screen edges often
			if (pick[0])
				y1 = y0;
			else
				x1 = x0;
		end
		send_line(x0, y0, x1, y1, COLOR_W'($urandom_range(255)));
		sender_gap(idle_pct);
	endtask

	task automatic test_basic_lines;
		send_line(12'sd0, 12'sd0, 12'sd0, 12'sd0, 8'd0);
		send_line(12'sd63, 12'sd63, 12'sd63, 12'sd63, 8'd255);
		send_line(-12'sd1, 12'sd5, -12'sd1, 12'sd5, 8'd17);
		send_line(12'sd0, 12'sd0, 12'sd63, 12'sd63, 8'd90);
		send_line(12'sd63, 12'sd0, 12'sd0, 12'sd63, 8'd91);
		send_line(12'sd3, 12'sd1, 12'sd60, 12'sd20, 8'd33);
		send_line(12'sd10, 12'sd60, 12'sd2, 12'sd3, 8'd44);
		drain_lines();
	endtask

	task automatic test_clipping_extremes;
		// a full-range run that crosses the whole screen in x, then in y
		send_line(12'sh800, 12'sd10, 12'sd2047, 12'sd10, 8'd255);
		send_line(12'sd5, 12'sd2047, 12'sd5, 12'sh800, 8'd0);
		// anti-diagonal through the whole range that never touches the screen
		send_line(12'sd2047, 12'sh800, 12'sh800, 12'sd2047, 8'd128);
		send_line(12'sd100, 12'sd100, 12'sd200, 12'sd150, 8'd7);
		send_line(12'sd64, 12'sd0, 12'sd64, 12'sd63, 8'd8);
		send_line(-12'sd10, 12'sd30, 12'sd30, -12'sd10, 8'd9);
		drain_lines();
	endtask

	task automatic test_rotations;
		logic [ROT_W-1:0] rots[4] = '{crlr_pkg::ROT_90, crlr_pkg::ROT_180,
			crlr_pkg::ROT_270, crlr_pkg::ROT_0};
		foreach (rots[i]) begin
			write_rotation(rots[i]);
			send_line(12'sd0, 12'sd0, 12'sd63, 12'sd0, 8'd200 + 8'(i));
			send_line(12'sd0, 12'sd63, -12'sd5, 12'sd70, 8'd100 + 8'(i));
			send_line(12'sd2, 12'sd40, 12'sd30, 12'sd5, 8'd50 + 8'(i));
			drain_lines();
		end
	endtask

	task automatic test_random_phase(input logic [ROT_W-1:0] rot, input int items,
			input int idle_pct);
		write_rotation(rot);
		repeat (items)
			random_line(idle_pct);
		drain_lines();
	endtask

	// sender holds off until the block has returned everything
	task automatic test_drained_pause;
		repeat (6) begin
			random_line(0);
			drain_lines();
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_lines();
		test_clipping_extremes();
		test_rotations();
		test_random_phase(crlr_pkg::ROT_90, 50, 0);
		test_random_phase(crlr_pkg::ROT_270, 50, 57);
		test_random_phase(crlr_pkg::ROT_180, 50, 21);
		test_random_phase(crlr_pkg::ROT_0, 50, 0);
		write_rotation(crlr_pkg::ROT_270);
		test_drained_pause();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/crlr_pkg.sv
sv/crlr_seq.sv
sv/crlr_dp.sv
sv/clipped_rotated_line_rasterizer_unit.sv
sv/crlr_checker.sv
verif/tb_clipped_rotated_line_rasterizer_unit.sv
